// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the gradient color block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define AGC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define AGC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/agc_pkg.sv =====
// Package of the animated gradient color block: field widths, fixed-point
// constants, segment types, color table and the quarter-wave sine table.
// No dependencies; every other RTL file but assert_macros.svh imports it.
`default_nettype none

package agc_pkg;

  localparam int POS_W   = 17;
  localparam int TIME_W  = 32;
  localparam int CHAN_W  = 8;
  localparam int PHASE_W = 16;
  localparam int DIFF_W  = 15;

  // Quarter-wave sine table, SINE_TABLE_DEPTH + 1 entries in Q1.15.
  localparam int SINE_TABLE_DEPTH = 256;
  localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH + 1);

  localparam logic [15:0] K_MOVE    = 16'd55706;
  localparam logic [12:0] K_STRETCH = 13'd7864;
  localparam logic [14:0] K_SPATIAL = 15'd29491;
  localparam logic [20:0] K_DRIFT   = 21'd2050696;
  localparam logic [9:0]  K_WOBBLE  = 10'd983;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam logic [15:0] SEG1_START   = 16'd21627;
  localparam logic [15:0] SEG2_START   = 16'd43254;
  localparam logic [14:0] SEG_NARROW_W = 15'd21627;
  localparam logic [14:0] SEG_WIDE_W   = 15'd22282;

  // floor(2^46 / width), used to divide a Q0.16 offset by a segment width.
  localparam logic [31:0] RECIP_NARROW = 32'((64'd1 << 46) / 64'd21627);
  localparam logic [31:0] RECIP_WIDE   = 32'((64'd1 << 46) / 64'd22282);

  typedef enum logic [1:0] {
    SEG_RG = 2'd0,
    SEG_GB = 2'd1,
    SEG_BR = 2'd2
  } seg_t;

  // Segment and offset into it, handed from the phase front end to the shader.
  typedef struct packed {
    seg_t              seg;
    logic [DIFF_W-1:0] diff;
  } seg_item_t;

  // Fixed colors in Q1.16, rows red, green, blue; columns R, G, B.
  localparam logic [16:0] SEG_COLOR [3][3] = '{
    '{17'd65536, 17'd3932,  17'd10486},
    '{17'd3932,  17'd58982, 17'd14418},
    '{17'd5243,  17'd26214, 17'd65536}
  };

  typedef logic [15:0] sine_rom_t [SINE_TABLE_DEPTH + 1];

  // Two truncating Q2.30 multiplies by x: next odd power of the series.
  function automatic logic [63:0] taylor_next(input logic [63:0] term, input logic [63:0] x);
    logic [63:0] t;
    t = (term * x) >> 30;
    t = (t * x) >> 30;
    return t;
  endfunction

  // sin(pi/2 * idx / depth) in Q1.15 by an 11th-order series in Q2.30.
  function automatic logic [15:0] sine_entry(input logic [63:0] idx);
    logic [63:0] x;
    logic [63:0] sum;
    logic [63:0] term;
    x    = (HALF_PI_Q30 * idx) / SINE_TABLE_DEPTH;
    sum  = x;
    term = taylor_next(x, x) / 64'd6;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = taylor_next(term, x) / 64'd20;
    sum  = sum + term;
    term = taylor_next(term, x) / 64'd42;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = taylor_next(term, x) / 64'd72;
    sum  = sum + term;
    term = taylor_next(term, x) / 64'd110;
    sum  = (sum >= term) ? sum - term : 64'd0;
    sum  = (sum * 64'd32768 + 64'd536870912) >> 30;
    if (sum > 64'd32768) begin
      sum = 64'd32768;
    end
    return sum[15:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      rom[i] = sine_entry(64'(i));
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

// ===== rtl/agc_in_if.sv =====
// Input channel of the gradient color block: valid, ready, position and time.
// Depends on agc_pkg for the field widths.
`default_nettype none

interface agc_in_if;
  import agc_pkg::*;

  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  position;
  logic [TIME_W-1:0] time_stamp;

  modport source (output valid, output position, output time_stamp, input ready);
  modport sink   (input valid, input position, input time_stamp, output ready);
endinterface

`default_nettype wire

// ===== rtl/agc_out_if.sv =====
// Result channel of the gradient color block: valid, ready and one RGB color.
// Depends on agc_pkg for the channel width.
`default_nettype none

interface agc_out_if;
  import agc_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

// ===== rtl/agc_phase.sv =====
// Front end of the gradient color pipeline: position and time to a color
// segment and the Q0.16 offset into it. Uses agc_pkg and agc_in_if.
`default_nettype none

module agc_phase (
  input  wire logic           clk,
  input  wire logic           rst_n,
  agc_in_if.sink              in_chan,
  output logic                mid_valid,
  input  wire logic           mid_ready,
  output agc_pkg::seg_item_t  mid_item
);
  import agc_pkg::*;

  localparam int STAGES = 5;

  logic [STAGES-1:0] vld_r;
  logic [STAGES:0]   rdy;

  // Stage registers.
  logic [15:0]         move_r;
  logic [13:0]         stretch_r;
  logic [15:0]         drift_r;
  logic [15:0]         angle_r;
  logic [15:0]         ms2_r;
  logic [15:0]         mag_r;
  logic                neg_r;
  logic [15:0]         ms3_r;
  logic [15:0]         phase_r;
  seg_item_t           item_r;

  logic [47:0]         move_prod;
  logic [30:0]         stretch_prod;
  logic [52:0]         drift_prod;
  logic [28:0]         spatial_prod;
  logic [15:0]         angle_nxt;
  logic [15:0]         ms_nxt;
  logic [1:0]          quarter;
  logic [14:0]         frac;
  logic [SINE_IDX_W+13:0] idx_prod;
  logic [SINE_IDX_W-1:0]  idx;
  logic [15:0]         mag_nxt;
  logic [25:0]         wob_prod;
  logic [9:0]          wob;
  logic [15:0]         phase_nxt;
  seg_item_t           item_nxt;

  // A stage takes new data when it is empty or its successor moves on.
  always_comb begin
    rdy[STAGES] = mid_ready;
    for (int i = STAGES - 1; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_chan.valid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (rdy[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  assign in_chan.ready = rdy[0];
  assign mid_valid     = vld_r[STAGES-1];
  assign mid_item      = item_r;

  // Stage 1: the three products on the inputs.
  always_comb begin
    move_prod    = 48'(in_chan.time_stamp) * 48'(K_MOVE);
    stretch_prod = 31'(in_chan.position) * 31'(K_STRETCH) + 31'h8000;
    drift_prod   = 53'(in_chan.time_stamp) * 53'(K_DRIFT) + (53'd1 << 31);
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      move_r    <= move_prod[31:16];
      stretch_r <= stretch_prod[29:16];
      drift_r   <= drift_prod[47:32];
    end
  end

  // Stage 2: sine angle in Q0.16 turns, and the part of the phase without wobble.
  always_comb begin
    spatial_prod = 29'(stretch_r) * 29'(K_SPATIAL) + 29'h8000;
    angle_nxt    = 16'(spatial_prod[28:16]) + drift_r;
    ms_nxt       = move_r + 16'(stretch_r);
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      angle_r <= angle_nxt;
      ms2_r   <= ms_nxt;
    end
  end

  // Stage 3: quarter-wave lookup, mirrored in odd quarters.
  always_comb begin
    quarter  = angle_r[15:14];
    frac     = {1'b0, angle_r[13:0]};
    if (quarter[0]) begin
      frac = 15'd16384 - frac;
    end
    idx_prod = (SINE_IDX_W + 14)'(frac) * (SINE_IDX_W + 14)'(SINE_TABLE_DEPTH);
    idx      = idx_prod[SINE_IDX_W+13:14];
    mag_nxt  = SINE_ROM[idx];
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      mag_r <= mag_nxt;
      neg_r <= quarter[1];
      ms3_r <= ms2_r;
    end
  end

  // Stage 4: scaled wobble added or taken off, wrapping within one turn.
  always_comb begin
    wob_prod  = 26'(mag_r) * 26'(K_WOBBLE) + 26'h4000;
    wob       = wob_prod[24:15];
    phase_nxt = neg_r ? ms3_r - 16'(wob) : ms3_r + 16'(wob);
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      phase_r <= phase_nxt;
    end
  end

  // Stage 5: segment choice and offset from the segment start.
  always_comb begin
    if (phase_r < SEG1_START) begin
      item_nxt.seg  = SEG_RG;
      item_nxt.diff = phase_r[DIFF_W-1:0];
    end else if (phase_r < SEG2_START) begin
      item_nxt.seg  = SEG_GB;
      item_nxt.diff = DIFF_W'(phase_r - SEG1_START);
    end else begin
      item_nxt.seg  = SEG_BR;
      item_nxt.diff = DIFF_W'(phase_r - SEG2_START);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      item_r <= item_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/agc_shade.sv =====
// Back end of the gradient color pipeline: segment offset to smoothstep weight
// to an 8-bit RGB color. Uses agc_pkg and agc_out_if.
`default_nettype none

module agc_shade (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              mid_valid,
  output logic                   mid_ready,
  input  wire agc_pkg::seg_item_t mid_item,
  agc_out_if.source              out_chan
);
  import agc_pkg::*;

  localparam int STAGES = 6;

  logic [STAGES-1:0] vld_r;
  logic [STAGES:0]   rdy;

  seg_item_t    item1_r;
  logic [15:0]  quot_r;
  seg_t         seg2_r;
  logic [15:0]  u2_r;
  seg_t         seg3_r;
  logic [15:0]  usq_r;
  logic [15:0]  u3_r;
  seg_t         seg4_r;
  logic [16:0]  w_r;
  logic [32:0]  c_r [3];
  logic [CHAN_W-1:0] rgb_r [3];

  logic [31:0]  recip;
  logic [46:0]  quot_prod;
  logic [14:0]  seg_width;
  logic [30:0]  num;
  logic [30:0]  qw;
  logic [30:0]  rem;
  logic [15:0]  u_nxt;
  logic [32:0]  usq_prod;
  logic [17:0]  k_coef;
  logic [33:0]  w_prod;
  logic [16:0]  w_nxt;
  logic [1:0]   cur_idx;
  logic [1:0]   nxt_idx;
  logic signed [17:0] delta;
  logic signed [35:0] blend;
  logic signed [35:0] c_full;
  logic [32:0]  c_nxt [3];
  logic [41:0]  scaled;
  logic [CHAN_W-1:0] rgb_nxt [3];

  always_comb begin
    rdy[STAGES] = out_chan.ready;
    for (int i = STAGES - 1; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= mid_valid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (rdy[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  assign mid_ready      = rdy[0];
  assign out_chan.valid = vld_r[STAGES-1];
  assign out_chan.red   = rgb_r[0];
  assign out_chan.green = rgb_r[1];
  assign out_chan.blue  = rgb_r[2];

  // Stage 1: quotient estimate by the reciprocal of the segment width.
  // It is exact or one short.
  always_comb begin
    recip     = (mid_item.seg == SEG_BR) ? RECIP_WIDE : RECIP_NARROW;
    quot_prod = 47'(mid_item.diff) * 47'(recip);
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      item1_r <= mid_item;
      quot_r  <= quot_prod[45:30];
    end
  end

  // Stage 2: correct the estimate by the remainder.
  always_comb begin
    seg_width = (item1_r.seg == SEG_BR) ? SEG_WIDE_W : SEG_NARROW_W;
    num       = {item1_r.diff, 16'h0000};
    qw        = 31'(quot_r) * 31'(seg_width);
    rem       = num - qw;
    u_nxt     = (rem >= 31'(seg_width)) ? quot_r + 16'd1 : quot_r;
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      u2_r   <= u_nxt;
      seg2_r <= item1_r.seg;
    end
  end

  // Stage 3: u squared, rounded to Q0.16.
  always_comb begin
    usq_prod = 33'(u2_r) * 33'(u2_r) + 33'h8000;
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      usq_r  <= usq_prod[31:16];
      u3_r   <= u2_r;
      seg3_r <= seg2_r;
    end
  end

  // Stage 4: smoothstep weight u*u*(3-2u), held to one.
  always_comb begin
    k_coef = 18'd196608 - {1'b0, u3_r, 1'b0};
    w_prod = 34'(usq_r) * 34'(k_coef) + 34'h8000;
    w_nxt  = (w_prod[33:16] > 18'd65536) ? 17'd65536 : w_prod[32:16];
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      w_r    <= w_nxt;
      seg4_r <= seg3_r;
    end
  end

  // Stage 5: mix the segment's two colors per channel in Q1.32.
  always_comb begin
    unique case (seg4_r)
      SEG_RG:  begin cur_idx = 2'd0; nxt_idx = 2'd1; end
      SEG_GB:  begin cur_idx = 2'd1; nxt_idx = 2'd2; end
      SEG_BR:  begin cur_idx = 2'd2; nxt_idx = 2'd0; end
      default: begin cur_idx = 2'd0; nxt_idx = 2'd1; end
    endcase
    delta  = '0;
    blend  = '0;
    c_full = '0;
    for (int j = 0; j < 3; j++) begin
      delta  = $signed({1'b0, SEG_COLOR[nxt_idx][2'(j)]})
             - $signed({1'b0, SEG_COLOR[cur_idx][2'(j)]});
      blend  = delta * $signed({1'b0, w_r});
      c_full = $signed({3'b000, SEG_COLOR[cur_idx][2'(j)], 16'h0000}) + blend;
      c_nxt[j] = c_full[35] ? 33'd0 : c_full[32:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      c_r <= c_nxt;
    end
  end

  // Stage 6: scale by 255 with rounding and clamp to 8 bits.
  always_comb begin
    scaled = '0;
    for (int j = 0; j < 3; j++) begin
      scaled = (42'(c_r[j]) << 8) - 42'(c_r[j]) + (42'd1 << 31);
      rgb_nxt[j] = (scaled[41:32] > 10'd255) ? 8'd255 : scaled[39:32];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      rgb_r <= rgb_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/animated_gradient_color.sv =====
// Top level of the animated gradient color block: phase front end and shader.
// Uses agc_pkg, agc_in_if, agc_out_if, agc_phase, agc_shade, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// For each item (a Q1.16 position along the strip and a Q16.16 time stamp) the
// block returns one 8-bit RGB color of a red, green, blue cycle that drifts with
// time and wobbles along the strip. It is an eleven-stage pipeline that takes
// one item per clock while its output is not stalled; the depth is set by the
// chain of multiplies: time and position scaling, the sine angle, the wobble,
// division by the segment width through a reciprocal and its correction, the
// two smoothstep products, the color mix and the scale to 8 bits. Each stage
// holds its item when the next one is full, so a stalled output backs up stage
// by stage and no item is lost or repeated. There is no configuration; reset
// clears only the valid flags of the stages, and the sine table is constant
// logic.
module animated_gradient_color (
  input  wire logic clk,
  input  wire logic rst_n,
  agc_in_if.sink    in_chan,
  agc_out_if.source out_chan
);
  import agc_pkg::*;

  logic      mid_valid;
  logic      mid_ready;
  seg_item_t mid_item;
  logic      mid_diff_ok;
  logic      mid_stall;

  agc_phase u_phase (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .mid_valid (mid_valid),
    .mid_ready (mid_ready),
    .mid_item  (mid_item)
  );

  agc_shade u_shade (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_valid (mid_valid),
    .mid_ready (mid_ready),
    .mid_item  (mid_item),
    .out_chan  (out_chan)
  );

  assign mid_diff_ok = (mid_item.seg == SEG_BR) ? (mid_item.diff < SEG_WIDE_W)
                                                : (mid_item.diff < SEG_NARROW_W);
  assign mid_stall   = mid_valid && !mid_ready;

  `AGC_ASSERT_IMP(a_mid_diff_in_range, mid_valid, mid_diff_ok, "segment offset past width")
  `AGC_ASSERT_NXT(a_mid_hold, mid_stall, mid_valid && $stable(mid_item), "stalled item changed")

endmodule

`default_nettype wire
